FILE: hdl/qmi_pkg.sv
// ----------------------------------------------------------------------------
// qmi_pkg
// Shared types and codes for the queue with middle insertion.
// ----------------------------------------------------------------------------
package qmi_pkg;

   // Field widths fixed by the transaction format
   localparam int VALUE_W  = 32;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   // Request kinds
   localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

endpackage

FILE: hdl/queue_with_middle_insert.sv
// ----------------------------------------------------------------------------
// queue_with_middle_insert
// FIFO of signed 32-bit values with push at back, insert at the middle and
// pop at front. Two ring halves in RAM keep the front half at ceil(n/2).
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit up)              | tuser
//  req_     | in        | value[31:0]                     | req_type[1:0]
//  rsp_     | out       | front_value[31:0], occupancy    | status[1:0]
//
//  Every transaction passes the two sequencer states: the accept cycle issues
//  the RAM reads and writes and updates the ring pointers, then ST_FINISH
//  performs the rebalancing move (back-half head to front-half tail) using the
//  registered read data and loads the result register. Reset is synchronous and
//  clears state, pointers, counts and result valid, not payload or RAM contents.
//  A stalled result holds the next request off until the result is taken.
// ----------------------------------------------------------------------------
module queue_with_middle_insert
   import qmi_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [VALUE_W-1:0]    req_tdata,   // value
   input  logic [REQ_W-1:0]      req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // front_value, occupancy, zero pad
   output logic [((VALUE_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   localparam int H      = (CAPACITY + 1) / 2;
   localparam int AW     = (H > 1) ? $clog2(H) : 1;
   localparam int CW     = $clog2(H + 1);
   localparam int SW     = CW + 1;
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int RSP_DW = ((VALUE_W + OCC_W + 7) / 8) * 8;
   localparam logic [OCC_W-1:0] CAP_N = OCC_W'(CAPACITY);

   state_type state_ff, state_in;

   // ring pointers and counts
   logic [AW-1:0] fh_ff, fh_in, bh_ff, bh_in;
   logic [CW-1:0] fc_ff, fc_in, bc_ff, bc_in;

   // per-transaction context carried into ST_FINISH
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                pop_ff, pop_in;
   logic                move_ff, move_in;
   logic [AW-1:0]       move_addr_ff, move_addr_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   // RAM ports
   logic               f_we, f_re, b_we, b_re;
   logic [AW-1:0]      f_wa, f_ra, b_wa, b_ra;
   logic [VALUE_W-1:0] f_wd, b_wd, f_rd, b_rd;

   logic               accept, finish, out_free;
   logic [OCC_W-1:0]   n_now, n_after;
   logic               n_even, full;
   logic [SW-1:0]      tail_f_sum, tail_b_sum;
   logic [AW-1:0]      tail_f, tail_b, bh_next, bh_prev, fh_next;

   qmi_ram #(.DEPTH(H), .AW(AW)) u_front (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_wa),
      .wr_data (f_wd),
      .rd_en   (f_re),
      .rd_addr (f_ra),
      .rd_data (f_rd)
   );

   qmi_ram #(.DEPTH(H), .AW(AW)) u_back (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_wa),
      .wr_data (b_wd),
      .rd_en   (b_re),
      .rd_addr (b_ra),
      .rd_data (b_rd)
   );

   // occupancy and ring address arithmetic
   assign n_now      = OCC_W'(fc_ff) + OCC_W'(bc_ff);
   assign n_after    = OCC_W'(fc_ff) + OCC_W'(bc_ff);
   assign n_even     = ~n_now[0];
   assign full       = (n_now >= CAP_N);
   assign tail_f_sum = SW'(fh_ff) + SW'(fc_ff);
   assign tail_b_sum = SW'(bh_ff) + SW'(bc_ff);
   assign tail_f     = (tail_f_sum >= SW'(H)) ? AW'(tail_f_sum - SW'(H)) : AW'(tail_f_sum);
   assign tail_b     = (tail_b_sum >= SW'(H)) ? AW'(tail_b_sum - SW'(H)) : AW'(tail_b_sum);
   assign fh_next    = (fh_ff == AW'(H - 1)) ? '0 : fh_ff + AW'(1);
   assign bh_next    = (bh_ff == AW'(H - 1)) ? '0 : bh_ff + AW'(1);
   assign bh_prev    = (bh_ff == '0) ? AW'(H - 1) : bh_ff - AW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && out_free) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
         end
         ST_FINISH: begin
            finish = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign accept   = req_tvalid & req_tready;

   // request decode, pointer update and RAM control
   always_comb begin
      fh_in        = fh_ff;
      fc_in        = fc_ff;
      bh_in        = bh_ff;
      bc_in        = bc_ff;
      status_in    = status_ff;
      pop_in       = pop_ff;
      move_in      = move_ff;
      move_addr_in = move_addr_ff;
      f_we = 1'b0; f_wa = tail_f; f_wd = req_tdata; f_re = 1'b0; f_ra = fh_ff;
      b_we = 1'b0; b_wa = tail_b; b_wd = req_tdata; b_re = 1'b0; b_ra = bh_ff;

      // rebalancing move: back-half head lands on front-half tail
      if (finish && move_ff) begin
         f_we = 1'b1;
         f_wa = move_addr_ff;
         f_wd = b_rd;
      end

      if (accept) begin
         status_in    = STAT_OK;
         pop_in       = 1'b0;
         move_in      = 1'b0;
         move_addr_in = tail_f;
         case (req_tuser)
            REQ_PUSH, REQ_INSERT: begin
               if (full) begin
                  status_in = STAT_FULL;
               end else if (n_even) begin
                  if (req_tuser == REQ_PUSH && bc_ff != '0) begin
                     // push at back tail, move back head forward next cycle
                     b_we    = 1'b1;
                     b_re    = 1'b1;
                     bh_in   = bh_next;
                     fc_in   = fc_ff + CW'(1);
                     move_in = 1'b1;
                  end else begin
                     // new entry would be moved straight on: write front tail
                     f_we  = 1'b1;
                     fc_in = fc_ff + CW'(1);
                  end
               end else if (req_tuser == REQ_PUSH) begin
                  b_we  = 1'b1;
                  bc_in = bc_ff + CW'(1);
               end else begin
                  // middle insert goes in front of the back-half head
                  b_we  = 1'b1;
                  b_wa  = bh_prev;
                  bh_in = bh_prev;
                  bc_in = bc_ff + CW'(1);
               end
            end
            REQ_POP: begin
               if (fc_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else begin
                  f_re   = 1'b1;
                  pop_in = 1'b1;
                  fh_in  = fh_next;
                  if (n_even) begin
                     b_re    = 1'b1;
                     bh_in   = bh_next;
                     bc_in   = bc_ff - CW'(1);
                     move_in = 1'b1;
                  end else begin
                     fc_in = fc_ff - CW'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_value_in  = pop_ff ? f_rd : '0;
         rsp_occ_in    = n_after;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fh_ff        <= '0;
         fc_ff        <= '0;
         bh_ff        <= '0;
         bc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fh_ff        <= fh_in;
         fc_ff        <= fc_in;
         bh_ff        <= bh_in;
         bc_ff        <= bc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      pop_ff        <= pop_in;
      move_ff       <= move_in;
      move_addr_ff  <= move_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DW'({rsp_occ_ff, rsp_value_ff});

   // front half always holds ceil(n/2) entries
   a_balance: assert property (@(posedge clock) disable iff (reset)
      (fc_ff == bc_ff) || (fc_ff == bc_ff + CW'(1)))
      else $error("half counts out of balance");

   // ST_FINISH always produces a result
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> rsp_valid_ff)
      else $error("result not loaded after transaction");

   // a result with an error status carries a zero value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> (rsp_value_ff == '0))
      else $error("value returned with error status");

   // occupancy never exceeds capacity
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      n_now <= CAP_N)
      else $error("occupancy beyond capacity");

endmodule

FILE: hdl/qmi_ram.sv
// ----------------------------------------------------------------------------
// qmi_ram
// Simple dual-port synchronous RAM for one half of the queue, one write port
// and one read port, read data registered.
// ----------------------------------------------------------------------------
module qmi_ram
   import qmi_pkg::*;
#(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
